FILE: hdl/pbfe_pkg.sv
// Package for the capture-stream frame extractor: codes, result types and helpers.
// Used by pcap_bus_frame_extractor_core; depends on nothing else.
package pbfe_pkg;

  localparam int unsigned MaxRecordLen = 65535;
  localparam int unsigned PosW = 17;

  localparam logic [31:0] MagicMicro     = 32'ha1b2c3d4;
  localparam logic [31:0] MagicNano      = 32'ha1b23c4d;
  localparam logic [31:0] MagicMicroSwap = 32'hd4c3b2a1;
  localparam logic [31:0] MagicNanoSwap  = 32'h4d3cb2a1;

  localparam logic [15:0] LinkCan      = 16'd227;
  localparam logic [15:0] LinkLin      = 16'd254;
  localparam logic [15:0] LinkEthernet = 16'd1;
  localparam logic [15:0] LinkFlexray  = 16'd259;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DESC    = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_MAGIC     = 2'd0,
    ERR_TOO_LONG  = 2'd1,
    ERR_SHORT     = 2'd2,
    ERR_TRUNCATED = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    BUS_CAN      = 3'd0,
    BUS_CANFD    = 3'd1,
    BUS_LIN      = 3'd2,
    BUS_ETHERNET = 3'd3,
    BUS_FLEXRAY  = 3'd4
  } bus_e;

  typedef enum logic [1:0] {
    PH_GLOBAL  = 2'd0,
    PH_RECHDR  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  // Descriptor or error result.
  typedef struct packed {
    kind_e       kind;
    logic [2:0]  bus;
    logic [28:0] frame_id;
    logic [7:0]  length;
    logic [31:0] ts_seconds;
    logic [41:0] ts_nanos;
    logic        fr_channel;
    logic [5:0]  fr_cycle;
    logic        fr_static;
    logic [1:0]  error_code;
  } mid_t;

  // All results caused by one input transfer, in output order.
  typedef struct packed {
    logic       data_v;
    logic [7:0] data_byte;
    logic       mid_v;
    mid_t       mid;
    logic       fin_v;
  } entry_t;

  function automatic logic [31:0] byte_swap(input logic [31:0] v);
    byte_swap = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

FILE: hdl/pcap_bus_frame_extractor_core.sv
// Top level of the capture-stream frame extractor: byte parser and result queue.
// Depends on pbfe_pkg.
//
// Channel   Dir  Bits  Contents
// s_axis    in   8+1   tdata: in_byte; tlast: end_of_file
// m_axis    out  136+3 tdata: result fields; tuser: kind; tlast: last
//
// One input byte is parsed per cycle; its up to three results are queued as one entry.
// Each result is a separate output transfer, so a byte with three results holds the output
// for three transfers. The two-entry queue sets input ready: no byte is taken while full.
// Reset returns the parser to the global header; end of file does the same.
// Stalls on the output side fill the queue and then hold the input.
module pcap_bus_frame_extractor_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] in_byte
  input  logic         s_axis_tlast_i,   // end_of_file
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [7:0] data_byte, [10:8] bus, [39:11] frame_id, [47:40] length,
  // [79:48] ts_seconds, [121:80] ts_nanos, [122] fr_channel, [128:123] fr_cycle,
  // [129] fr_static, [131:130] error_code, [135:132] zero
  output logic [135:0] m_axis_tdata_o,
  output logic [1:0]   m_axis_tuser_o,   // [1:0] kind
  output logic         m_axis_tlast_o    // last
);

  localparam logic [pbfe_pkg::PosW-1:0] MaxLen = pbfe_pkg::PosW'(pbfe_pkg::MaxRecordLen);

  // Parser state.
  pbfe_pkg::phase_e          phase_q, phase_d;
  logic [pbfe_pkg::PosW-1:0] pos_q, pos_d;
  logic [31:0]               word_q, word_d;
  logic                      be_q, be_d;
  logic                      micro_q, micro_d;
  logic [15:0]               link_q, link_d;
  logic [31:0]               sec_q, sec_d;
  logic [31:0]               frac_q, frac_d;
  logic [41:0]               nanos_q;
  logic [pbfe_pkg::PosW-1:0] rlen_q, rlen_d;
  logic [7:0]                slot_q [8];
  logic [7:0]                slot_d [8];
  logic                      halted_q, halted_d;

  pbfe_pkg::entry_t          ent;

  logic in_xfer;
  logic out_xfer;

  // Parse one byte and collect its results.
  always_comb begin
    logic [31:0]               wa;
    logic [31:0]               w;
    logic [7:0]                b;
    logic [pbfe_pkg::PosW-1:0] p;
    logic [pbfe_pkg::PosW-1:0] len;
    logic [pbfe_pkg::PosW:0]   lim;
    logic [7:0]                dlc;
    logic [3:0]                lm;
    logic [7:0]                fm;
    logic [6:0]                ft;
    logic [10:0]               fid;
    logic                      ok;
    logic                      skip;
    logic                      frerr;

    b = s_axis_tdata_i;
    p = pos_q;
    len = rlen_q;
    phase_d = phase_q;
    pos_d = pos_q;
    word_d = word_q;
    be_d = be_q;
    micro_d = micro_q;
    link_d = link_q;
    sec_d = sec_q;
    frac_d = frac_q;
    rlen_d = rlen_q;
    slot_d = slot_q;
    halted_d = halted_q;
    ent = '0;
    wa = {b, word_q[31:8]};
    w = be_q ? pbfe_pkg::byte_swap(wa) : wa;
    lim = '0;
    dlc = '0;
    lm = '0;
    fm = '0;
    ft = '0;
    fid = '0;
    ok = 1'b0;
    skip = 1'b0;
    frerr = 1'b0;

    if (!halted_q) begin
      unique case (phase_q)
        pbfe_pkg::PH_GLOBAL: begin
          word_d = wa;
          if (p == pbfe_pkg::PosW'(3)) begin
            be_d = (wa == pbfe_pkg::MagicMicroSwap) || (wa == pbfe_pkg::MagicNanoSwap);
            micro_d = (wa == pbfe_pkg::MagicMicro) || (wa == pbfe_pkg::MagicMicroSwap);
            if (wa != pbfe_pkg::MagicMicro && wa != pbfe_pkg::MagicNano &&
                wa != pbfe_pkg::MagicMicroSwap && wa != pbfe_pkg::MagicNanoSwap) begin
              ent.mid_v = 1'b1;
              ent.mid.kind = pbfe_pkg::KIND_ERROR;
              ent.mid.error_code = pbfe_pkg::ERR_MAGIC;
              halted_d = 1'b1;
            end
          end
          if (p >= pbfe_pkg::PosW'(23)) begin
            link_d = w[15:0];
            phase_d = pbfe_pkg::PH_RECHDR;
            pos_d = '0;
          end else begin
            pos_d = p + 1'b1;
          end
        end
        pbfe_pkg::PH_RECHDR: begin
          word_d = wa;
          if (p == pbfe_pkg::PosW'(3)) sec_d = w;
          if (p == pbfe_pkg::PosW'(7)) frac_d = w;
          if (p == pbfe_pkg::PosW'(11)) begin
            rlen_d = (w > 32'(pbfe_pkg::MaxRecordLen)) ? MaxLen + 1'b1 : w[pbfe_pkg::PosW-1:0];
          end
          if (p >= pbfe_pkg::PosW'(15)) begin
            ok = (link_q == pbfe_pkg::LinkCan && len >= pbfe_pkg::PosW'(8)) ||
                 (link_q == pbfe_pkg::LinkLin && len >= pbfe_pkg::PosW'(5)) ||
                 (link_q == pbfe_pkg::LinkEthernet && len >= pbfe_pkg::PosW'(14)) ||
                 (link_q == pbfe_pkg::LinkFlexray && len >= pbfe_pkg::PosW'(2));
            if (len > MaxLen) begin
              ent.mid_v = 1'b1;
              ent.mid.kind = pbfe_pkg::KIND_ERROR;
              ent.mid.error_code = pbfe_pkg::ERR_TOO_LONG;
              halted_d = 1'b1;
            end else if (!ok) begin
              ent.mid_v = 1'b1;
              ent.mid.kind = pbfe_pkg::KIND_ERROR;
              ent.mid.error_code = pbfe_pkg::ERR_SHORT;
              halted_d = 1'b1;
            end else begin
              phase_d = pbfe_pkg::PH_PAYLOAD;
              pos_d = '0;
              for (int i = 0; i < 8; i++) slot_d[i] = '0;
            end
          end else begin
            pos_d = p + 1'b1;
          end
        end
        default: begin
          // Capture the header bytes that the descriptor needs.
          if (p == pbfe_pkg::PosW'(0))  slot_d[0] = b;
          if (p == pbfe_pkg::PosW'(1))  slot_d[1] = b;
          if (p == pbfe_pkg::PosW'(2))  slot_d[2] = b;
          if (p == pbfe_pkg::PosW'(3))  slot_d[3] = b;
          if (p == pbfe_pkg::PosW'(4))  slot_d[4] = b;
          if (p == pbfe_pkg::PosW'(6))  slot_d[5] = b;
          if (p == pbfe_pkg::PosW'(12)) slot_d[6] = b;
          if (p == pbfe_pkg::PosW'(13)) slot_d[7] = b;

          dlc = (slot_d[4] > 8'd64) ? 8'd64 : slot_d[4];
          lm = (slot_d[1][3:0] > 4'd8) ? 4'd8 : slot_d[1][3:0];
          ft = slot_d[0][6:0];
          fm = (len < pbfe_pkg::PosW'(7)) ? 8'd0 :
               ((len - pbfe_pkg::PosW'(7) > pbfe_pkg::PosW'(254)) ? 8'd254 :
                8'(len - pbfe_pkg::PosW'(7)));
          fid = {slot_d[3][3:0], slot_d[2][7:1]};

          if (link_q == pbfe_pkg::LinkCan) begin
            lim = (pbfe_pkg::PosW+1)'(8) + (pbfe_pkg::PosW+1)'(dlc);
            ent.data_v = p >= pbfe_pkg::PosW'(8) && {1'b0, p} < lim && {1'b0, len} >= lim;
          end else if (link_q == pbfe_pkg::LinkLin) begin
            lim = (pbfe_pkg::PosW+1)'(5) + (pbfe_pkg::PosW+1)'(lm);
            ent.data_v = p >= pbfe_pkg::PosW'(5) && {1'b0, p} < lim && {1'b0, len} >= lim;
          end else if (link_q == pbfe_pkg::LinkEthernet) begin
            ent.data_v = 1'b1;
          end else begin
            frerr = p == '0 && !(ft == 7'd2 || (ft == 7'd1 && len >= pbfe_pkg::PosW'(7)));
            skip = ft == 7'd2;
            lim = (pbfe_pkg::PosW+1)'(7) + (pbfe_pkg::PosW+1)'(fm);
            ent.data_v = !frerr && !skip && p >= pbfe_pkg::PosW'(7) && {1'b0, p} < lim;
          end
          ent.data_byte = b;

          if (frerr) begin
            ent.mid_v = 1'b1;
            ent.mid.kind = pbfe_pkg::KIND_ERROR;
            ent.mid.error_code = pbfe_pkg::ERR_SHORT;
            halted_d = 1'b1;
          end else if ({1'b0, p} + 1'b1 >= {1'b0, len}) begin
            phase_d = pbfe_pkg::PH_RECHDR;
            pos_d = '0;
            if (!skip) begin
              ent.mid_v = 1'b1;
              ent.mid.kind = pbfe_pkg::KIND_DESC;
              ent.mid.ts_seconds = sec_q;
              ent.mid.ts_nanos = nanos_q;
              if (link_q == pbfe_pkg::LinkCan) begin
                ent.mid.bus = slot_d[0][7] ? pbfe_pkg::BUS_CANFD : pbfe_pkg::BUS_CAN;
                ent.mid.frame_id = {slot_d[0][4:0], slot_d[1], slot_d[2], slot_d[3]};
                ent.mid.length = dlc;
              end else if (link_q == pbfe_pkg::LinkLin) begin
                ent.mid.bus = pbfe_pkg::BUS_LIN;
                ent.mid.frame_id = 29'(slot_d[2]);
                ent.mid.length = 8'(lm);
              end else if (link_q == pbfe_pkg::LinkEthernet) begin
                ent.mid.bus = pbfe_pkg::BUS_ETHERNET;
                ent.mid.frame_id = 29'({slot_d[6], slot_d[7]});
                ent.mid.length = (len > pbfe_pkg::PosW'(255)) ? 8'd255 : len[7:0];
              end else begin
                ent.mid.bus = pbfe_pkg::BUS_FLEXRAY;
                ent.mid.frame_id = 29'(fid);
                ent.mid.length = fm;
                ent.mid.fr_channel = slot_d[0][7];
                ent.mid.fr_cycle = slot_d[5][5:0];
                ent.mid.fr_static = fid >= 11'd1 && fid <= 11'd31;
              end
            end
          end else begin
            pos_d = p + 1'b1;
          end
        end
      endcase
    end

    // End of file: report an unfinished header or record, then restart.
    if (s_axis_tlast_i) begin
      if (!halted_d) begin
        if (phase_d == pbfe_pkg::PH_GLOBAL) begin
          ent.mid_v = 1'b1;
          ent.mid.kind = pbfe_pkg::KIND_ERROR;
          ent.mid.error_code = (pos_d < pbfe_pkg::PosW'(4)) ? pbfe_pkg::ERR_MAGIC
                                                             : pbfe_pkg::ERR_TRUNCATED;
        end else if (phase_d == pbfe_pkg::PH_PAYLOAD || pos_d != '0) begin
          ent.mid_v = 1'b1;
          ent.mid.kind = pbfe_pkg::KIND_ERROR;
          ent.mid.error_code = pbfe_pkg::ERR_TRUNCATED;
        end
      end
      ent.fin_v = 1'b1;
      phase_d = pbfe_pkg::PH_GLOBAL;
      pos_d = '0;
      word_d = '0;
      be_d = 1'b0;
      micro_d = 1'b1;
      link_d = '0;
      sec_d = '0;
      frac_d = '0;
      rlen_d = '0;
      for (int i = 0; i < 8; i++) slot_d[i] = '0;
      halted_d = 1'b0;
    end
  end

  // Result queue: two entries, each holding all results of one byte.
  pbfe_pkg::entry_t q_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  pbfe_pkg::entry_t head;
  logic             push, pop;
  logic [2:0]       flags;

  assign s_axis_tready_o = cnt_q != 2'd2;
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;
  assign head = q_q[rd_q];
  assign flags = {head.data_v, head.mid_v, head.fin_v};
  assign m_axis_tvalid_o = cnt_q != 2'd0;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;
  assign push = in_xfer && (ent.data_v || ent.mid_v || ent.fin_v);
  assign pop = out_xfer && ($countones(flags) == 1);

  // Present the first pending result of the head entry.
  always_comb begin
    m_axis_tdata_o = '0;
    m_axis_tuser_o = pbfe_pkg::KIND_DONE;
    m_axis_tlast_o = $countones(flags) == 1;
    if (head.data_v) begin
      m_axis_tuser_o = pbfe_pkg::KIND_PAYLOAD;
      m_axis_tdata_o[7:0] = head.data_byte;
    end else if (head.mid_v) begin
      m_axis_tuser_o = head.mid.kind;
      m_axis_tdata_o[10:8] = head.mid.bus;
      m_axis_tdata_o[39:11] = head.mid.frame_id;
      m_axis_tdata_o[47:40] = head.mid.length;
      m_axis_tdata_o[79:48] = head.mid.ts_seconds;
      m_axis_tdata_o[121:80] = head.mid.ts_nanos;
      m_axis_tdata_o[122] = head.mid.fr_channel;
      m_axis_tdata_o[128:123] = head.mid.fr_cycle;
      m_axis_tdata_o[129] = head.mid.fr_static;
      m_axis_tdata_o[131:130] = head.mid.error_code;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pbfe_pkg::PH_GLOBAL;
      pos_q <= '0;
      word_q <= '0;
      be_q <= 1'b0;
      micro_q <= 1'b1;
      link_q <= '0;
      sec_q <= '0;
      frac_q <= '0;
      rlen_q <= '0;
      for (int i = 0; i < 8; i++) slot_q[i] <= '0;
      halted_q <= 1'b0;
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (in_xfer) begin
        phase_q <= phase_d;
        pos_q <= pos_d;
        word_q <= word_d;
        be_q <= be_d;
        micro_q <= micro_d;
        link_q <= link_d;
        sec_q <= sec_d;
        frac_q <= frac_d;
        rlen_q <= rlen_d;
        slot_q <= slot_d;
        halted_q <= halted_d;
      end
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Payload registers: queue slots and the scaled timestamp fraction.
  always_ff @(posedge clk_i) begin
    nanos_q <= micro_q ? 42'(frac_q) * 42'd1000 : 42'(frac_q);
    if (push) q_q[wr_q] <= ent;
    if (out_xfer && !pop) begin
      if (head.data_v) q_q[rd_q].data_v <= 1'b0;
      else q_q[rd_q].mid_v <= 1'b0;
    end
  end

  // Queued entries always carry at least one pending result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> flags != 3'b000)
    else $error("queued entry has no pending result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("result queue count out of range");

  // A finished-stream result is always the last one of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == pbfe_pkg::KIND_DONE) |-> m_axis_tlast_o)
    else $error("stream finished is not last");

  // End of file always leaves the parser at the global header.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tlast_i) |=> (phase_q == pbfe_pkg::PH_GLOBAL && !halted_q))
    else $error("parser did not restart after end of file");

endmodule
